[hw/rtl/round_robin_task_scheduler_assert.svh]
// Assertion macros used by the scheduler top level.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define RRTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

[hw/rtl/rrts_pkg.sv]
// Shared types, codes and constants of the round-robin task scheduler.
package rrts_pkg;

    localparam int MAX_TASKS_DEF = 16;

    // Index and count fields in the shared structs are sized for the largest table.
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_ADD      = 3'd1,
        CMD_KILL     = 3'd2,
        CMD_KILL_CUR = 3'd3,
        CMD_START    = 3'd4,
        CMD_STOP     = 3'd5,
        CMD_CONT     = 3'd6
    } t_cmd;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef enum logic [1:0] {
        SCAN_FIND,
        SCAN_KILL,
        SCAN_LOAD
    } t_scan_op;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  task_pid;
        logic [15:0] quantum;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        switched;
        logic        running;
        logic [3:0]  current_slot;
        logic        current_valid;
        logic [7:0]  current_pid;
    } t_out;

    // Broadcast write into the slot cells.
    typedef struct packed {
        logic             wr_all;
        logic             wr_elapsed;
        logic [IDX_W-1:0] addr;
        logic [7:0]       pid;
        logic [15:0]      quantum;
        logic [15:0]      elapsed;
    } t_wr;

    // Sweep control, held steady while a packet walks the chain.
    typedef struct packed {
        t_scan_op         op;
        logic [IDX_W-1:0] key;
        logic [IDX_W-1:0] base;
        logic [CNT_W-1:0] count;
    } t_scan;

    // Packet handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic             valid;
        logic             hit_a;
        logic [IDX_W-1:0] idx_a;
        logic             hit_b;
        logic [IDX_W-1:0] idx_b;
        logic [7:0]       pid;
        logic [15:0]      quantum;
        logic [15:0]      elapsed;
    } t_pkt;

endpackage

[hw/rtl/rrts_cell.sv]
// One task slot of the scheduler chain: slot storage plus one packet stage.
module rrts_cell #(
    parameter int INDEX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rrts_pkg::t_wr   i_wr,
    input  rrts_pkg::t_scan i_scan,
    input  rrts_pkg::t_pkt  i_pkt,
    output rrts_pkg::t_pkt  o_pkt
);

    localparam logic [rrts_pkg::IDX_W-1:0] MY_IDX = rrts_pkg::IDX_W'(INDEX);
    localparam logic [rrts_pkg::CNT_W-1:0] MY_CNT = rrts_pkg::CNT_W'(INDEX);

    logic [7:0]     r_pid, n_pid;
    logic           r_alive, n_alive;
    logic [15:0]    r_quantum, n_quantum;
    logic [15:0]    r_elapsed, n_elapsed;
    rrts_pkg::t_pkt r_pkt, n_pkt;

    logic wr_hit;
    logic in_range;
    logic alive_eff;

    assign wr_hit    = (i_wr.addr == MY_IDX);
    assign in_range  = (MY_CNT < i_scan.count);
    assign alive_eff = r_alive && in_range;

    always_comb begin
        n_pid     = r_pid;
        n_alive   = r_alive;
        n_quantum = r_quantum;
        n_elapsed = r_elapsed;
        n_pkt     = i_pkt;

        if (wr_hit && i_wr.wr_all) begin
            n_pid     = i_wr.pid;
            n_alive   = 1'b1;
            n_quantum = i_wr.quantum;
            n_elapsed = i_wr.elapsed;
        end
        if (wr_hit && i_wr.wr_elapsed) begin
            n_elapsed = i_wr.elapsed;
        end

        if (i_pkt.valid) begin
            unique case (i_scan.op)
                rrts_pkg::SCAN_FIND: begin
                    // Slot a: first alive after the base; slot b: first alive up to it.
                    if (alive_eff && (MY_IDX > i_scan.base) && !i_pkt.hit_a) begin
                        n_pkt.hit_a = 1'b1;
                        n_pkt.idx_a = MY_IDX;
                    end
                    if (alive_eff && (MY_IDX <= i_scan.base) && !i_pkt.hit_b) begin
                        n_pkt.hit_b = 1'b1;
                        n_pkt.idx_b = MY_IDX;
                    end
                end
                rrts_pkg::SCAN_KILL: begin
                    if (in_range && (r_pid == i_scan.key[7:0]) && !i_pkt.hit_a) begin
                        n_pkt.hit_a = 1'b1;
                        n_alive     = 1'b0;
                    end
                end
                rrts_pkg::SCAN_LOAD: begin
                    if (i_scan.key == MY_IDX) begin
                        n_pkt.pid     = r_pid;
                        n_pkt.quantum = r_quantum;
                        n_pkt.elapsed = r_elapsed;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid     <= n_pid;
        r_alive   <= n_alive;
        r_quantum <= n_quantum;
        r_elapsed <= n_elapsed;
        if (!i_rst_n) begin
            r_pkt <= '0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

endmodule

[hw/rtl/rrts_ctrl.sv]
// Scheduler control: command decode, current-task registers and sweep sequencing.
module rrts_ctrl #(
    parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rrts_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output rrts_pkg::t_out  o_out_data,
    output rrts_pkg::t_wr   o_wr,
    output rrts_pkg::t_scan o_scan,
    output rrts_pkg::t_pkt  o_launch,
    input  rrts_pkg::t_pkt  i_result
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int KW = (CW > 8) ? CW : 8;

    rrts_pkg::t_state   r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_cur_idx, n_cur_idx;
    logic               r_cur_set, n_cur_set;
    logic               r_active, n_active;
    logic [7:0]         r_cur_pid, n_cur_pid;
    logic [15:0]        r_cur_quantum, n_cur_quantum;
    logic [15:0]        r_cur_elapsed, n_cur_elapsed;
    rrts_pkg::t_scan_op r_scan_op, n_scan_op;
    logic [7:0]         r_key, n_key;
    logic               r_launch_v, n_launch_v;
    logic               r_switched, n_switched;
    logic               r_kill_cur, n_kill_cur;
    logic               r_out_valid, n_out_valid;
    rrts_pkg::t_out     r_out_data, n_out_data;

    logic          accept;
    logic          has_cur;
    logic          fire;
    logic [1:0]    status_v;
    logic [CW-1:0] wrap_idx;
    logic [IW+3:0] slot_ext;

    assign o_in_stall = (r_state != rrts_pkg::ST_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign has_cur    = r_cur_set && (CW'(r_cur_idx) < r_count);
    assign wrap_idx   = CW'(r_cur_idx) + CW'(1);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_cur_idx     = r_cur_idx;
        n_cur_set     = r_cur_set;
        n_active      = r_active;
        n_cur_pid     = r_cur_pid;
        n_cur_quantum = r_cur_quantum;
        n_cur_elapsed = r_cur_elapsed;
        n_scan_op     = r_scan_op;
        n_key         = r_key;
        n_launch_v    = 1'b0;
        n_switched    = r_switched;
        n_kill_cur    = r_kill_cur;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_data    = r_out_data;
        o_wr          = '0;
        fire          = 1'b0;
        status_v      = rrts_pkg::STAT_IGNORED;

        unique case (r_state)
            rrts_pkg::ST_IDLE: begin
                if (accept) begin
                    fire       = 1'b1;
                    n_switched = 1'b0;
                    unique case (i_in_data.command)
                        rrts_pkg::CMD_TICK: begin
                            if (r_active && has_cur) begin
                                status_v = rrts_pkg::STAT_DONE;
                                if (r_cur_elapsed > r_cur_quantum) begin
                                    n_cur_elapsed   = '0;
                                    o_wr.wr_elapsed = 1'b1;
                                    o_wr.addr       = rrts_pkg::IDX_W'(r_cur_idx);
                                    o_wr.elapsed    = '0;
                                    n_scan_op       = rrts_pkg::SCAN_FIND;
                                    n_launch_v      = 1'b1;
                                    n_state         = rrts_pkg::ST_SCAN;
                                    fire            = 1'b0;
                                end else if (r_cur_elapsed != 16'hFFFF) begin
                                    n_cur_elapsed   = r_cur_elapsed + 16'd1;
                                    o_wr.wr_elapsed = 1'b1;
                                    o_wr.addr       = rrts_pkg::IDX_W'(r_cur_idx);
                                    o_wr.elapsed    = r_cur_elapsed + 16'd1;
                                end
                            end
                        end
                        rrts_pkg::CMD_ADD: begin
                            if (r_count == CW'(MAX_TASKS)) begin
                                status_v = rrts_pkg::STAT_FULL;
                            end else begin
                                o_wr.wr_all  = 1'b1;
                                o_wr.addr    = rrts_pkg::IDX_W'(r_count[IW-1:0]);
                                o_wr.pid     = i_in_data.task_pid;
                                o_wr.quantum = i_in_data.quantum;
                                o_wr.elapsed = '0;
                                n_count      = r_count + CW'(1);
                                status_v     = rrts_pkg::STAT_DONE;
                            end
                        end
                        rrts_pkg::CMD_KILL: begin
                            if (KW'(i_in_data.task_pid) < KW'(r_count)) begin
                                n_scan_op  = rrts_pkg::SCAN_KILL;
                                n_key      = i_in_data.task_pid;
                                n_kill_cur = 1'b0;
                                n_launch_v = 1'b1;
                                n_state    = rrts_pkg::ST_SCAN;
                                fire       = 1'b0;
                            end
                        end
                        rrts_pkg::CMD_KILL_CUR: begin
                            if (has_cur) begin
                                n_active = 1'b1;
                                status_v = rrts_pkg::STAT_DONE;
                                if (KW'(r_cur_pid) < KW'(r_count)) begin
                                    n_scan_op  = rrts_pkg::SCAN_KILL;
                                    n_key      = r_cur_pid;
                                    n_kill_cur = 1'b1;
                                    n_launch_v = 1'b1;
                                    n_state    = rrts_pkg::ST_SCAN;
                                    fire       = 1'b0;
                                end
                            end
                        end
                        rrts_pkg::CMD_START: begin
                            if (r_count != '0) begin
                                n_cur_idx  = '0;
                                n_cur_set  = 1'b1;
                                n_active   = 1'b1;
                                n_scan_op  = rrts_pkg::SCAN_LOAD;
                                n_key      = '0;
                                n_launch_v = 1'b1;
                                n_state    = rrts_pkg::ST_SCAN;
                                fire       = 1'b0;
                            end
                        end
                        rrts_pkg::CMD_STOP: begin
                            n_active = 1'b0;
                            status_v = rrts_pkg::STAT_DONE;
                        end
                        rrts_pkg::CMD_CONT: begin
                            if (r_cur_set && (r_count != '0)) begin
                                n_active = 1'b1;
                                status_v = rrts_pkg::STAT_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rrts_pkg::ST_SCAN: begin
                if (i_result.valid) begin
                    unique case (r_scan_op)
                        rrts_pkg::SCAN_FIND: begin
                            // Round-robin order: slots after the current one, then from zero.
                            if (i_result.hit_a) begin
                                n_cur_idx  = i_result.idx_a[IW-1:0];
                                n_switched = 1'b1;
                            end else if (i_result.hit_b) begin
                                n_cur_idx  = i_result.idx_b[IW-1:0];
                                n_switched = 1'b1;
                            end else begin
                                n_cur_idx = (wrap_idx >= r_count) ? '0 : wrap_idx[IW-1:0];
                                n_active  = 1'b0;
                            end
                            n_scan_op  = rrts_pkg::SCAN_LOAD;
                            n_key      = 8'(n_cur_idx);
                            n_launch_v = 1'b1;
                        end
                        rrts_pkg::SCAN_LOAD: begin
                            n_cur_pid     = i_result.pid;
                            n_cur_quantum = i_result.quantum;
                            n_cur_elapsed = i_result.elapsed;
                            status_v      = rrts_pkg::STAT_DONE;
                            fire          = 1'b1;
                            n_state       = rrts_pkg::ST_IDLE;
                        end
                        rrts_pkg::SCAN_KILL: begin
                            status_v = (r_kill_cur || i_result.hit_a) ? rrts_pkg::STAT_DONE
                                                                       : rrts_pkg::STAT_IGNORED;
                            fire     = 1'b1;
                            n_state  = rrts_pkg::ST_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = rrts_pkg::ST_IDLE;
            end
        endcase

        slot_ext = (IW + 4)'(n_cur_idx);
        if (fire) begin
            n_out_valid                = 1'b1;
            n_out_data.status          = status_v;
            n_out_data.switched        = n_switched;
            n_out_data.running         = n_active;
            n_out_data.current_slot    = n_cur_set ? slot_ext[3:0] : 4'd0;
            n_out_data.current_valid   = n_cur_set;
            n_out_data.current_pid     = n_cur_set ? n_cur_pid : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrts_pkg::ST_IDLE;
            r_count     <= '0;
            r_cur_idx   <= '0;
            r_cur_set   <= 1'b0;
            r_active    <= 1'b0;
            r_launch_v  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur_idx   <= n_cur_idx;
            r_cur_set   <= n_cur_set;
            r_active    <= n_active;
            r_launch_v  <= n_launch_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_pid     <= n_cur_pid;
        r_cur_quantum <= n_cur_quantum;
        r_cur_elapsed <= n_cur_elapsed;
        r_scan_op     <= n_scan_op;
        r_key         <= n_key;
        r_switched    <= n_switched;
        r_kill_cur    <= n_kill_cur;
        r_out_data    <= n_out_data;
    end

    always_comb begin
        o_scan.op    = r_scan_op;
        o_scan.key   = rrts_pkg::IDX_W'(r_key);
        o_scan.base  = rrts_pkg::IDX_W'(r_cur_idx);
        o_scan.count = rrts_pkg::CNT_W'(r_count);
        o_launch       = '0;
        o_launch.valid = r_launch_v;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hw/rtl/round_robin_task_scheduler.sv]
// Top level of the round-robin task scheduler: control plus a chain of slot cells.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+----------------------------
//  command | in        | i_in_valid / o_in_stall     | i_in_data  (rrts_pkg::t_in)
//  result  | out       | o_out_valid / i_out_stall   | o_out_data (rrts_pkg::t_out)
//
// Add, stop, continue, ignored commands and non-expiring ticks finish without a chain sweep.
// Start, and a kill or kill-current whose pid is below the task count, send one packet
// down the slot chain.
// A tick that expires the quantum takes two chain sweeps, a find and then a load.
// The chain has one cell per slot.
// Reset is synchronous and needs no clearing pass; slot contents are not reset and are ignored until added.
// A command is taken while idle and the result register is empty or being read in that cycle.
module round_robin_task_scheduler #(
    parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rrts_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rrts_pkg::t_out o_out_data
);

    `include "round_robin_task_scheduler_assert.svh"

    rrts_pkg::t_wr   w_wr;
    rrts_pkg::t_scan w_scan;
    rrts_pkg::t_pkt  w_chain [0:MAX_TASKS];
    logic [MAX_TASKS:0] w_pkt_valid;

    rrts_ctrl #(
        .MAX_TASKS(MAX_TASKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_wr        (w_wr),
        .o_scan      (w_scan),
        .o_launch    (w_chain[0]),
        .i_result    (w_chain[MAX_TASKS])
    );

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        rrts_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr),
            .i_scan  (w_scan),
            .i_pkt   (w_chain[g]),
            .o_pkt   (w_chain[g+1])
        );
    end

    for (genvar v = 0; v <= MAX_TASKS; v++) begin : g_valid
        assign w_pkt_valid[v] = w_chain[v].valid;
    end

    // Only one sweep packet is ever in the chain.
    `RRTS_ASSERT_IMP(a_one_packet, i_clk, i_rst_n, 1'b1, $onehot0(w_pkt_valid))
    // While a packet walks the chain, no new command is taken.
    `RRTS_ASSERT_IMP(a_stall_in_sweep, i_clk, i_rst_n, |w_pkt_valid, o_in_stall)
    // A command is never taken while a stalled result would be overwritten.
    `RRTS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_in_valid && !o_in_stall,
                     !o_out_valid || !i_out_stall)
    // Without a current task the slot and pid fields read zero.
    `RRTS_ASSERT_IMP(a_no_cur_zero, i_clk, i_rst_n,
                     o_out_valid && !o_out_data.current_valid,
                     (o_out_data.current_slot == 4'd0) && (o_out_data.current_pid == 8'd0))

endmodule

[dv/round_robin_task_scheduler_tb.sv]
// Self-checking testbench for the round-robin task scheduler: directed table, random traffic.
module round_robin_task_scheduler_tb;
    import rrts_pkg::*;

    localparam int NSLOTS = MAX_TASKS_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 2 * (NSLOTS + 2) + 10;
    localparam int PHASE_ITEMS = 230;
    localparam int HOLD_TICKS = 20;
    localparam logic [2:0] CMD_UNDEF = 3'd7;

    localparam t_out IGN_IDLE = '{STAT_IGNORED, 1'b0, 1'b0, 4'd0, 1'b0, 8'd0};
    localparam t_out DONE_IDLE = '{STAT_DONE, 1'b0, 1'b0, 4'd0, 1'b0, 8'd0};
    localparam t_out STARTED = '{STAT_DONE, 1'b0, 1'b1, 4'd0, 1'b1, 8'd1};
    localparam t_out UNTYPED = '0;

    typedef struct packed {
        t_in  item;
        bit   typed;
        t_out res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    // Shadow copy of the task table and scheduler flags.
    bit [7:0]    tbl_pid [NSLOTS];
    bit          tbl_alive [NSLOTS];
    bit [15:0]   tbl_quantum [NSLOTS];
    bit [15:0]   tbl_elapsed [NSLOTS];
    int unsigned n_tasks = 0;
    int unsigned cur_idx = 0;
    bit          cur_set = 1'b0;
    bit          sched_on = 1'b0;

    t_out sched_reports [$];
    int   mismatches = 0;
    int   cycle_count = 0;
    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    int   rcv_hold = 0;

    // Three tasks are added and scheduled, then every slot is killed so that an
    // expiring tick finds nothing alive and scheduling stops.
    t_row plan [26] = '{
        '{'{CMD_TICK, 8'd0, 16'd0}, 1'b1, IGN_IDLE},
        '{'{CMD_START, 8'd0, 16'd0}, 1'b1, IGN_IDLE},
        '{'{CMD_CONT, 8'd0, 16'd0}, 1'b1, IGN_IDLE},
        '{'{CMD_KILL_CUR, 8'd0, 16'd0}, 1'b1, IGN_IDLE},
        '{'{CMD_KILL, 8'hFF, 16'hFFFF}, 1'b1, IGN_IDLE},
        '{'{CMD_UNDEF, 8'd0, 16'd0}, 1'b1, IGN_IDLE},
        '{'{CMD_STOP, 8'd0, 16'd0}, 1'b1, DONE_IDLE},
        '{'{CMD_ADD, 8'd1, 16'd0}, 1'b1, DONE_IDLE},
        '{'{CMD_ADD, 8'd0, 16'd1}, 1'b1, DONE_IDLE},
        '{'{CMD_ADD, 8'd2, 16'hFFFF}, 1'b1, DONE_IDLE},
        '{'{CMD_CONT, 8'd0, 16'd0}, 1'b1, IGN_IDLE},
        '{'{CMD_START, 8'd0, 16'd0}, 1'b1, STARTED},
        '{'{CMD_TICK, 8'd0, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_TICK, 8'd0, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_TICK, 8'd0, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_TICK, 8'd0, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_TICK, 8'd0, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_KILL, 8'd2, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_STOP, 8'd0, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_KILL_CUR, 8'd0, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_START, 8'd0, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_KILL, 8'd0, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_KILL, 8'd1, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_TICK, 8'd0, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_TICK, 8'd0, 16'd0}, 1'b0, UNTYPED},
        '{'{CMD_CONT, 8'd0, 16'd0}, 1'b0, UNTYPED}
    };

    round_robin_task_scheduler #(
        .MAX_TASKS(NSLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned wrap_next(input int unsigned s);
        return (s + 1 >= n_tasks) ? 0 : s + 1;
    endfunction

    // A kill only takes effect for a pid below the task count.
    function automatic bit retire_pid(input int unsigned pid);
        if (pid >= n_tasks) return 1'b0;
        for (int i = 0; i < n_tasks; i++) begin
            if (32'(tbl_pid[i]) == pid) begin
                tbl_alive[i] = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_out advance_scheduler(input t_in item);
        t_out        r;
        bit          has_cur;
        bit          killed;
        int unsigned c, s, scanned;
        r = '0;
        r.status = STAT_IGNORED;
        has_cur = cur_set && cur_idx < n_tasks;
        case (item.command)
            CMD_TICK: begin
                if (sched_on && has_cur) begin
                    c = cur_idx;
                    r.status = STAT_DONE;
                    if (tbl_elapsed[c] > tbl_quantum[c]) begin
                        tbl_elapsed[c] = '0;
                        s = wrap_next(c);
                        scanned = 0;
                        while (!tbl_alive[s] && scanned < n_tasks) begin
                            s = wrap_next(s);
                            scanned++;
                        end
                        cur_idx = s;
                        if (tbl_alive[s]) r.switched = 1'b1;
                        else sched_on = 1'b0;
                    end else if (tbl_elapsed[c] != 16'hFFFF) begin
                        tbl_elapsed[c] = tbl_elapsed[c] + 16'd1;
                    end
                end
            end
            CMD_ADD: begin
                if (n_tasks >= NSLOTS) begin
                    r.status = STAT_FULL;
                end else begin
                    tbl_pid[n_tasks] = item.task_pid;
                    tbl_alive[n_tasks] = 1'b1;
                    tbl_quantum[n_tasks] = item.quantum;
                    tbl_elapsed[n_tasks] = '0;
                    n_tasks++;
                    r.status = STAT_DONE;
                end
            end
            CMD_KILL: begin
                if (retire_pid(32'(item.task_pid))) r.status = STAT_DONE;
            end
            CMD_KILL_CUR: begin
                if (has_cur) begin
                    killed = retire_pid(32'(tbl_pid[cur_idx]));
                    sched_on = 1'b1;
                    r.status = STAT_DONE;
                end
            end
            CMD_START: begin
                if (n_tasks > 0) begin
                    cur_idx = 0;
                    cur_set = 1'b1;
                    sched_on = 1'b1;
                    r.status = STAT_DONE;
                end
            end
            CMD_STOP: begin
                sched_on = 1'b0;
                r.status = STAT_DONE;
            end
            CMD_CONT: begin
                if (cur_set && n_tasks > 0) begin
                    sched_on = 1'b1;
                    r.status = STAT_DONE;
                end
            end
            default: ;
        endcase
        r.running = sched_on;
        r.current_slot = cur_set ? 4'(cur_idx) : 4'd0;
        r.current_valid = cur_set;
        r.current_pid = (cur_set && cur_idx < NSLOTS) ? tbl_pid[cur_idx] : 8'd0;
        return r;
    endfunction

    // Mostly ticks with small quanta so that tasks rotate often; one slot is
    // kept free for the wide-quantum task at the end.
    function automatic t_in random_item();
        t_in item;
        int  pick;
        pick = $urandom_range(0, 99);
        item.task_pid = $urandom_range(0, 1) ? 8'($urandom_range(0, 19)) : 8'($urandom);
        item.quantum = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 255))
                                                    : 16'($urandom_range(0, 7));
        if (pick < 58) item.command = CMD_TICK;
        else if (pick < 68) item.command = (n_tasks < NSLOTS - 1) ? CMD_ADD : CMD_TICK;
        else if (pick < 74) item.command = CMD_KILL;
        else if (pick < 78) item.command = CMD_KILL_CUR;
        else if (pick < 83) item.command = CMD_START;
        else if (pick < 88) item.command = CMD_STOP;
        else if (pick < 97) item.command = CMD_CONT;
        else item.command = CMD_UNDEF;
        return item;
    endfunction

    task automatic send_cmd(input t_in item, input bit typed, input t_out typed_res,
                            output t_out predicted);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = advance_scheduler(item);
        sched_reports.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic await_reports();
        while (sched_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_report(input t_out got);
        t_out want;
        if (sched_reports.size() == 0) begin
            $error("result with no transaction pending: %p", got);
            mismatches++;
            return;
        end
        want = sched_reports.pop_front();
        cmp_field("status", 8'(want.status), 8'(got.status));
        cmp_field("switched", 8'(want.switched), 8'(got.switched));
        cmp_field("running", 8'(want.running), 8'(got.running));
        cmp_field("current_slot", 8'(want.current_slot), 8'(got.current_slot));
        cmp_field("current_valid", 8'(want.current_valid), 8'(got.current_valid));
        cmp_field("current_pid", want.current_pid, got.current_pid);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($isunknown(o_out_valid)) begin
                $error("o_out_valid: expected a known value, got %b", o_out_valid);
                mismatches++;
            end else if (o_out_valid && !i_out_stall) begin
                check_report(o_out_data);
            end
        end
    end

    // Receiver: a requested hold-off wins over random stalls.
    always @(negedge i_clk) begin
        if (rcv_hold > 0) begin
            i_out_stall <= 1'b1;
            rcv_hold <= rcv_hold - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("round_robin_task_scheduler_tb: FAIL");
            $finish;
        end
    end

    initial begin
        t_out        pred;
        t_in         item;
        int          counted;
        int unsigned target;
        snd_idle_pct = 17;
        rcv_idle_pct = 47;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) send_cmd(plan[k].item, plan[k].typed, plan[k].res, pred);

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 47 : 0;
            rcv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 17 : 0;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                send_cmd(random_item(), 1'b0, UNTYPED, pred);
                counted++;
                // Long receiver hold-off so that the input side backs up.
                if (ph == 0 && counted == 100) rcv_hold = 400;
                if (ph == 1 && counted == 150) begin
                    drop_valid();
                    await_reports();
                end
            end
        end

        // An unkillable task (pid above any task count) with the widest quantum:
        // rotate onto it and keep ticking on it.
        target = n_tasks;
        item = '{CMD_ADD, 8'hFF, 16'hFFFF};
        send_cmd(item, 1'b0, UNTYPED, pred);
        item = '{CMD_START, 8'd0, 16'd0};
        send_cmd(item, 1'b0, UNTYPED, pred);
        item = '{CMD_TICK, 8'd0, 16'd0};
        while (cur_idx != target) send_cmd(item, 1'b0, UNTYPED, pred);
        repeat (HOLD_TICKS) send_cmd(item, 1'b0, UNTYPED, pred);

        // Fill the table, then one add more reports it full.
        while (n_tasks < NSLOTS) begin
            item = random_item();
            item.command = CMD_ADD;
            send_cmd(item, 1'b0, UNTYPED, pred);
        end
        item = random_item();
        item.command = CMD_ADD;
        send_cmd(item, 1'b0, UNTYPED, pred);
        item = '{CMD_KILL, 8'hFF, 16'd0};
        send_cmd(item, 1'b0, UNTYPED, pred);

        drop_valid();
        await_reports();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("round_robin_task_scheduler_tb: PASS");
        end else begin
            $display("round_robin_task_scheduler_tb: FAIL");
        end
        $finish;
    end
endmodule
